>>> hw/rtl/buddy_block_allocator_core_defines.svh
// assertion macros used by the allocator core
`ifndef BUDDY_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define BBA_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// implication checked at every clock edge out of reset
`define BBA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/bba_pkg.sv
// types, constants and helpers of the buddy allocator
`default_nettype none

package bba_pkg;

  localparam int MAX_ORDER  = 20;
  localparam int NUM_ORDERS = MAX_ORDER + 1;
  localparam int ORD_W      = $clog2(NUM_ORDERS);
  localparam int OFF_W      = MAX_ORDER;
  localparam int REQ_W      = 24;
  localparam int OP_W       = 2;
  localparam int STAT_W     = 3;
  localparam int OUT_OFF_W  = 20;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_INIT    = 2'd1,
    OP_DESTROY = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_ZERO      = 3'd1,
    ST_NOT_INIT  = 3'd2,
    ST_TOO_LARGE = 3'd3,
    ST_NO_FREE   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SPLIT,
    S_FIN
  } fsm_t;

  // search wave handed from one order cell to the next
  typedef struct packed {
    logic             act;
    logic             hit;
    logic [OFF_W-1:0] base;
    logic [ORD_W-1:0] ord;
  } wave_t;

  // commands broadcast to every order cell
  typedef struct packed {
    logic             clr;
    logic             init;
    logic             split;
    logic [ORD_W-1:0] split_ord;
    logic [OFF_W-1:0] split_base;
  } cmd_t;

  function automatic logic [OUT_OFF_W-1:0] fit_offset(input logic [OFF_W-1:0] off);
    logic [63:0] wide;
    wide = 64'(off);
    return wide[OUT_OFF_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/bba_cell.sv
// one order cell: free flag and free block offset of a single order
`default_nettype none

module bba_cell
  import bba_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [ORD_W-1:0] idx,
  input  wire logic [REQ_W-1:0] req_m1,
  input  wire cmd_t             cmd,
  input  wire wave_t            wave_in,
  output wave_t                 wave_out
);

  logic             free_r, free_nxt;
  logic [OFF_W-1:0] off_r, off_nxt;
  logic             wave_act_r;
  wave_t            wave_r, wave_nxt;
  logic             big, take, is_top, split_here;

  // block of this order is large enough for the request
  assign big        = (req_m1 >> idx) == '0;
  assign take       = wave_in.act && !wave_in.hit && big && free_r;
  assign is_top     = idx == ORD_W'(MAX_ORDER);
  assign split_here = cmd.split && (idx < cmd.split_ord) && big;

  always_comb begin
    wave_nxt = wave_in;
    if (take) begin
      wave_nxt.hit  = 1'b1;
      wave_nxt.base = off_r;
      wave_nxt.ord  = idx;
    end
  end

  always_comb begin
    free_nxt = free_r;
    off_nxt  = off_r;
    if (cmd.clr) begin
      free_nxt = 1'b0;
    end else if (cmd.init) begin
      free_nxt = is_top;
      if (is_top) begin
        off_nxt = '0;
      end
    end else if (take) begin
      free_nxt = 1'b0;
    end else if (split_here) begin
      // upper half of the split block lands on this order
      free_nxt = 1'b1;
      off_nxt  = cmd.split_base | (OFF_W'(1) << idx);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r     <= 1'b0;
      wave_act_r <= 1'b0;
    end else begin
      free_r     <= free_nxt;
      wave_act_r <= wave_nxt.act;
    end
  end

  always_ff @(posedge clk) begin
    off_r  <= off_nxt;
    wave_r <= wave_nxt;
  end

  always_comb begin
    wave_out     = wave_r;
    wave_out.act = wave_act_r;
  end

endmodule

`default_nettype wire

>>> hw/rtl/buddy_block_allocator_core.sv
// Buddy allocator over a pool of 2^MAX_ORDER bytes, one order cell per order.
// Init, destroy, an unused operation code and an allocate rejected up front
// (not initialised, zero size, too large) give their result in the cycle
// after the item is taken. An allocate that goes to search runs in steps: a
// search wave walks up the chain of MAX_ORDER + 1 order cells one cell per
// cycle, the outcome at the top of the chain is captured, the found block is
// split into the lower cells, and the result register is loaded once the
// output is free. With no free block the split step drops out.
// One item is in work at a time; the next is taken once the block is back
// in idle and the result register can be loaded. Blocks are never freed, so
// each order holds at most one free block.
`default_nettype none

`include "buddy_block_allocator_core_defines.svh"

module buddy_block_allocator_core
  import bba_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [OP_W-1:0]      in_operation,
  input  wire logic [REQ_W-1:0]     in_request_bytes,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [OUT_OFF_W-1:0]      out_block_offset,
  output logic [STAT_W-1:0]         out_status
);

  fsm_t                 state_r, state_nxt;
  logic                 pool_ready_r, pool_ready_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_OFF_W-1:0] out_off_r, out_off_nxt;
  status_t              out_stat_r, out_stat_nxt;
  logic                 out_load, out_free;
  logic                 in_acc, launch, alloc_ok, too_large, zero_req;
  logic [REQ_W-1:0]     in_req_m1;
  logic [REQ_W-1:0]     req_m1_r;
  logic [REQ_W-1:0]     req_cells;
  logic                 hit_r;
  logic [OFF_W-1:0]     base_r;
  logic [ORD_W-1:0]     ord_r;
  op_t                  op;
  cmd_t                 cmd;
  wave_t                wave_launch;
  wave_t                waves [NUM_ORDERS];
  wave_t                wave_top;

  assign op        = op_t'(in_operation);
  assign out_free  = !out_valid_r || !out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign zero_req  = in_request_bytes == '0;
  assign in_req_m1 = in_request_bytes - REQ_W'(1);
  assign too_large = (in_req_m1 >> MAX_ORDER) != '0;
  assign alloc_ok  = (op == OP_ALLOC) && pool_ready_r && !zero_req && !too_large;
  assign launch    = in_acc && alloc_ok;
  // order 0 sees the wave in the launch cycle, before the request is registered
  assign req_cells = launch ? in_req_m1 : req_m1_r;

  always_comb begin
    wave_launch      = '0;
    wave_launch.act  = launch;
  end

  // chain of order cells, wave moves from order 0 upward
  for (genvar k = 0; k < NUM_ORDERS; k++) begin : g_cell
    bba_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .idx      (ORD_W'(k)),
      .req_m1   (req_cells),
      .cmd      (cmd),
      .wave_in  ((k == 0) ? wave_launch : waves[(k == 0) ? 0 : k - 1]),
      .wave_out (waves[k])
    );
  end

  assign wave_top = waves[NUM_ORDERS-1];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (launch) begin
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (wave_top.act) begin
          state_nxt = wave_top.hit ? S_SPLIT : S_FIN;
        end
      end
      S_SPLIT: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // outputs of the controller
  always_comb begin
    in_stall       = (state_r != S_IDLE) || !out_free;
    cmd            = '0;
    cmd.split_ord  = ord_r;
    cmd.split_base = base_r;
    out_load       = 1'b0;
    out_off_nxt    = '0;
    out_stat_nxt   = ST_OK;
    pool_ready_nxt = pool_ready_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && !alloc_ok) begin
          out_load = 1'b1;
          unique case (op)
            OP_ALLOC: begin
              if (!pool_ready_r) begin
                out_stat_nxt = ST_NOT_INIT;
              end else if (zero_req) begin
                out_stat_nxt = ST_ZERO;
              end else begin
                out_stat_nxt = ST_TOO_LARGE;
              end
            end
            OP_INIT: begin
              cmd.init       = 1'b1;
              pool_ready_nxt = 1'b1;
            end
            OP_DESTROY: begin
              cmd.clr        = 1'b1;
              pool_ready_nxt = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      S_SPLIT: begin
        cmd.split = 1'b1;
      end
      S_FIN: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_off_nxt  = hit_r ? fit_offset(base_r) : '0;
          out_stat_nxt = hit_r ? ST_OK : ST_NO_FREE;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pool_ready_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pool_ready_r <= pool_ready_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (launch) begin
      req_m1_r <= in_req_m1;
    end
    if (state_r == S_SEARCH && wave_top.act) begin
      hit_r  <= wave_top.hit;
      base_r <= wave_top.base;
      ord_r  <= wave_top.ord;
    end
    if (out_load) begin
      out_off_r  <= out_off_nxt;
      out_stat_r <= out_stat_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_block_offset = out_off_r;
  assign out_status       = out_stat_r;

  `BBA_ASSERT_IMP(a_launch_ready, launch, pool_ready_r, "search launched on an uninitialised pool")
  `BBA_ASSERT_IMP(a_wave_in_search, wave_top.act, state_r == S_SEARCH, "search wave outside search")
  `BBA_ASSERT_IMP(a_split_after_hit, state_r == S_SPLIT, $past(wave_top.hit), "split without a hit")
  `BBA_ASSERT_IMP(a_one_in_work, state_r != S_IDLE, in_stall, "item taken while one is in work")

endmodule

`default_nettype wire
